### hdl/oiss_pkg.sv
// Shared types, constants and helpers for the ordered integer sequence store.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing else.
package oiss_pkg;

  // Storage geometry.
  localparam int CAPACITY  = 64;
  localparam int CAP_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int SUM_W     = CNT_W + 1;

  // Fixed field widths of the beat ports.
  localparam int DATA_W    = 32;
  localparam int OPC_W     = 4;
  localparam int POS_W     = 7;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 7;
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Operation codes.
  typedef enum logic [OPC_W-1:0] {
    OP_QUERY      = 4'd0,
    OP_PUSH_FRONT = 4'd1,
    OP_PUSH_BACK  = 4'd2,
    OP_POP_FRONT  = 4'd3,
    OP_POP_BACK   = 4'd4,
    OP_CLEAR      = 4'd5,
    OP_REMOVE_EQ  = 4'd6,
    OP_INSERT_AT  = 4'd7,
    OP_CONTAINS   = 4'd8
  } opcode_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_FETCH,
    CS_STEP
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // take the beat and apply the part of it done at accept
    logic fetch;   // load the freshly read front or back entry
    logic step;    // one walk step: issue a read, handle the previous one
    logic finish;  // close a walk: insert write and count update, or remove count update
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic ins_mid;    // insert position falls strictly inside the store
    logic step_done;  // walk has issued and handled every read
  } dp_stat_t;

  // Physical slot of a logical position in the circular buffer.
  function automatic logic [CAP_W-1:0] phys_addr(logic [CAP_W-1:0] base,
                                                 logic [CNT_W-1:0] ofs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(ofs);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[CAP_W-1:0];
  endfunction

endpackage

### hdl/oiss_ctrl.sv
// Controller state machine of the ordered integer sequence store.
// Sequences the datapath through accept, fetch and walk steps.
// Depends on oiss_pkg.
module oiss_ctrl import oiss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [OPC_W-1:0] opcode_i,
  input  dp_stat_t         stat_i,
  output dp_cmd_t          cmd_o,
  output logic             busy,
  output logic             done_o
);

  ctrl_state_e state_q, state_d;
  logic        done_q, done_d;
  logic        is_pop, is_walk, is_ins;

  // State and result strobe registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Decode of the incoming operation.
  assign is_pop  = (opcode_i == OP_POP_FRONT) || (opcode_i == OP_POP_BACK);
  assign is_walk = (opcode_i == OP_REMOVE_EQ) || (opcode_i == OP_CONTAINS);
  assign is_ins  = (opcode_i == OP_INSERT_AT);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      CS_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          if (is_pop && !stat_i.empty) begin
            state_d = CS_FETCH;
          end else if ((is_walk && !stat_i.empty) ||
                       (is_ins && !stat_i.full && stat_i.ins_mid)) begin
            state_d = CS_STEP;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      CS_FETCH: begin
        cmd_o.fetch = 1'b1;
        done_d      = 1'b1;
        state_d     = CS_IDLE;
      end
      CS_STEP: begin
        if (stat_i.step_done) begin
          cmd_o.finish = 1'b1;
          done_d       = 1'b1;
          state_d      = CS_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != CS_IDLE);
  assign done_o = done_q;

endmodule

### hdl/oiss_dp.sv
// Datapath of the ordered integer sequence store: circular entry memory,
// head and count registers, cached front and back values, walk counters.
// Depends on oiss_pkg.
module oiss_dp import oiss_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [OPC_W-1:0]         opcode_i,
  input  logic signed [DATA_W-1:0] data_value_i,
  input  logic [POS_W-1:0]         insert_position_i,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [CNT_OUT_W-1:0]     entry_count_o,
  output logic signed [DATA_W-1:0] front_value_o,
  output logic signed [DATA_W-1:0] back_value_o,
  output logic                     is_empty_o,
  output logic                     found_o
);

  // Entry memory, one write and one registered read per cycle.
  logic [DATA_W-1:0] mem [CAPACITY];
  logic              we;
  logic [CAP_W-1:0]  waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata_q;

  // Control registers.
  logic [CAP_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic              found_q, found_d;
  logic              pend_q, pend_d;
  logic [OPC_W-1:0]  op_q, op_d;

  // Payload registers.
  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] front_q, front_d;
  logic [DATA_W-1:0] back_q, back_d;
  logic [CAP_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  end_q, end_d;
  logic [CNT_W-1:0]  wr_idx_q, wr_idx_d;
  logic [CNT_W-1:0]  pend_idx_q, pend_idx_d;

  logic             empty, full, ins_mid, rd_more;
  logic             push_f, push_b;
  logic [CAP_W-1:0] head_m1;

  // Flags derived from the current store.
  assign empty   = (count_q == '0);
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign ins_mid = (insert_position_i != '0) &&
                   (CMP_W'(insert_position_i) < CMP_W'(count_q));
  assign rd_more = (rd_idx_q != end_q);
  assign head_m1 = (head_q == '0) ? CAP_W'(CAPACITY - 1) : head_q - 1'b1;

  assign stat_o.empty     = empty;
  assign stat_o.full      = full;
  assign stat_o.ins_mid   = ins_mid;
  assign stat_o.step_done = !rd_more && !pend_q;

  // Next-state logic for every register and the memory ports.
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    status_d   = status_q;
    found_d    = found_q;
    pend_d     = pend_q;
    op_d       = op_q;
    val_d      = val_q;
    front_d    = front_q;
    back_d     = back_q;
    pos_d      = pos_q;
    rd_idx_d   = rd_idx_q;
    end_d      = end_q;
    wr_idx_d   = wr_idx_q;
    pend_idx_d = pend_idx_q;
    we         = 1'b0;
    waddr      = head_q;
    wdata      = val_q;
    raddr      = head_q;
    push_f     = 1'b0;
    push_b     = 1'b0;

    // New beat: latch operands and apply the part done at accept.
    if (cmd_i.accept) begin
      op_d     = opcode_i;
      val_d    = data_value_i;
      status_d = STS_DONE;
      found_d  = 1'b0;
      pend_d   = 1'b0;
      wr_idx_d = '0;
      unique case (opcode_i)
        OP_PUSH_FRONT: begin
          if (full) status_d = STS_FULL;
          else      push_f   = 1'b1;
        end
        OP_PUSH_BACK: begin
          if (full) status_d = STS_FULL;
          else      push_b   = 1'b1;
        end
        OP_INSERT_AT: begin
          if (full) begin
            status_d = STS_FULL;
          end else if (insert_position_i == '0) begin
            push_f = 1'b1;
          end else if (ins_mid) begin
            pos_d    = CAP_W'(insert_position_i);
            rd_idx_d = count_q - 1'b1;
            end_d    = CNT_W'(insert_position_i) - 1'b1;
          end else begin
            push_b = 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_d = STS_EMPTY;
          end else begin
            head_d  = phys_addr(head_q, CNT_W'(1));
            count_d = count_q - 1'b1;
            raddr   = phys_addr(head_q, CNT_W'(1));
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_d = STS_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
            if (count_q > CNT_W'(1)) begin
              raddr = phys_addr(head_q, count_q - CNT_W'(2));
            end
          end
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        OP_REMOVE_EQ, OP_CONTAINS: begin
          rd_idx_d = '0;
          end_d    = count_q;
        end
        default: begin
        end
      endcase

      // Pushes at either end write the new value directly.
      if (push_f) begin
        we      = 1'b1;
        waddr   = head_m1;
        wdata   = data_value_i;
        head_d  = head_m1;
        count_d = count_q + 1'b1;
        front_d = data_value_i;
        if (empty) back_d = data_value_i;
      end
      if (push_b) begin
        we      = 1'b1;
        waddr   = phys_addr(head_q, count_q);
        wdata   = data_value_i;
        count_d = count_q + 1'b1;
        back_d  = data_value_i;
        if (empty) front_d = data_value_i;
      end
    end

    // The entry read at accept becomes the new front or back.
    if (cmd_i.fetch) begin
      if (op_q == OP_POP_FRONT) front_d = rdata_q;
      else                      back_d  = rdata_q;
    end

    // Walk step: issue the next read and handle the one before it.
    if (cmd_i.step) begin
      if (rd_more) begin
        raddr      = phys_addr(head_q, rd_idx_q);
        pend_d     = 1'b1;
        pend_idx_d = rd_idx_q;
        if (op_q == OP_INSERT_AT) rd_idx_d = rd_idx_q - 1'b1;
        else                      rd_idx_d = rd_idx_q + 1'b1;
      end else begin
        pend_d = 1'b0;
      end
      if (pend_q) begin
        if (op_q == OP_CONTAINS) begin
          if (rdata_q == val_q) found_d = 1'b1;
        end else if (op_q == OP_REMOVE_EQ) begin
          // Compaction: kept entries slide down to the write index.
          if (rdata_q != val_q) begin
            we       = 1'b1;
            waddr    = phys_addr(head_q, wr_idx_q);
            wdata    = rdata_q;
            wr_idx_d = wr_idx_q + 1'b1;
            back_d   = rdata_q;
            if (wr_idx_q == '0) front_d = rdata_q;
          end
        end else begin
          // Insert: each entry moves one slot toward the back.
          we    = 1'b1;
          waddr = phys_addr(head_q, pend_idx_q + 1'b1);
          wdata = rdata_q;
        end
      end
    end

    // End of a walk.
    if (cmd_i.finish) begin
      if (op_q == OP_INSERT_AT) begin
        we      = 1'b1;
        waddr   = phys_addr(head_q, CNT_W'(pos_q));
        wdata   = val_q;
        count_d = count_q + 1'b1;
      end else if (op_q == OP_REMOVE_EQ) begin
        count_d = wr_idx_q;
      end
    end
  end

  // Entry memory.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      status_q <= STS_DONE;
      found_q  <= 1'b0;
      pend_q   <= 1'b0;
      op_q     <= OP_QUERY;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      status_q <= status_d;
      found_q  <= found_d;
      pend_q   <= pend_d;
      op_q     <= op_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    front_q    <= front_d;
    back_q     <= back_d;
    pos_q      <= pos_d;
    rd_idx_q   <= rd_idx_d;
    end_q      <= end_d;
    wr_idx_q   <= wr_idx_d;
    pend_idx_q <= pend_idx_d;
  end

  // Result fields; front and back read as zero when empty.
  assign status_o      = status_q;
  assign entry_count_o = CNT_OUT_W'(count_q);
  assign front_value_o = empty ? '0 : front_q;
  assign back_value_o  = empty ? '0 : back_q;
  assign is_empty_o    = empty;
  assign found_o       = found_q;

endmodule

### hdl/ordered_int_sequence_store_core.sv
// Top level of the ordered integer sequence store.
// Joins the controller oiss_ctrl and the datapath oiss_dp; uses oiss_pkg.
//
// A beat is taken when start is high and busy is low. Its result appears on
// the result ports for one cycle with done_o high; the receiver cannot stall,
// and a new beat may be started in that same cycle. Query, clear, pushes,
// inserts at either end, and rejected or ignored operations complete from
// the idle state. Pops pass through a fetch state for the memory read of the
// new end entry. Remove-equal and contains walk the stored entries through
// the single memory read port at one entry per cycle. An insert inside the
// store shifts the entries from the position onward one per cycle.
module ordered_int_sequence_store_core import oiss_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [OPC_W-1:0]         opcode_i,
  input  logic signed [DATA_W-1:0] data_value_i,
  input  logic [POS_W-1:0]         insert_position_i,
  output logic                     done_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [CNT_OUT_W-1:0]     entry_count_o,
  output logic signed [DATA_W-1:0] front_value_o,
  output logic signed [DATA_W-1:0] back_value_o,
  output logic                     is_empty_o,
  output logic                     found_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing.
  oiss_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  // Storage and result registers.
  oiss_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .opcode_i          (opcode_i),
    .data_value_i      (data_value_i),
    .insert_position_i (insert_position_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .status_o          (status_o),
    .entry_count_o     (entry_count_o),
    .front_value_o     (front_value_o),
    .back_value_o      (back_value_o),
    .is_empty_o        (is_empty_o),
    .found_o           (found_o)
  );

endmodule

### hdl/oiss_checker.sv
// Port-level checker for the ordered integer sequence store, bound to the
// top level. Depends on oiss_pkg.
module oiss_checker import oiss_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic [OPC_W-1:0]         opcode_i,
  input logic                     done_o,
  input logic [STAT_W-1:0]        status_o,
  input logic [CNT_OUT_W-1:0]     entry_count_o,
  input logic signed [DATA_W-1:0] front_value_o,
  input logic signed [DATA_W-1:0] back_value_o,
  input logic                     is_empty_o,
  input logic                     found_o
);

  // A query beat raises done_o in the next cycle and frees the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == OP_QUERY) |=> (done_o && !busy))
    else $error("query beat did not complete in one cycle");

  // Empty flag agrees with the reported count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with entry count");

  // An empty store reports zero front and back values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_empty_o) |-> (front_value_o == '0 && back_value_o == '0))
    else $error("empty store shows nonzero end values");

  // A push or insert rejected as full leaves the store at full capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STS_FULL) |-> (entry_count_o == CNT_OUT_W'(CAPACITY)))
    else $error("full status with store below capacity");

  // A hit can only come from a nonempty store and a completed operation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (status_o == STS_DONE && !is_empty_o))
    else $error("found flag on empty store or failed operation");

endmodule

bind ordered_int_sequence_store_core oiss_checker u_oiss_checker (.*);
